FILE: sv/chm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chm_pkg: shared types and constants for the chained hash map
// Operation and status codes, payload structs and sequencer states.
// ----------------------------------------------------------------------------
package chm_pkg;

  localparam int unsigned BucketsDefault     = 1024;
  localparam int unsigned PoolEntriesDefault = 1024;
  localparam int unsigned PayloadBitsDefault = 64;

  localparam logic [1:0] OpInsert = 2'd0;
  localparam logic [1:0] OpRemove = 2'd1;
  localparam logic [1:0] OpLookup = 2'd2;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StMissing = 2'd1;
  localparam logic [1:0] StFull    = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] key;
    logic [31:0] record_number;
    logic [63:0] record_payload;
  } chm_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] found_number;
    logic [63:0] found_payload;
  } chm_out_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HEAD,
    S_FREE,
    S_WALK_RD,
    S_WALK,
    S_LINK,
    S_FETCH,
    S_DONE
  } chm_state_e;

endpackage

FILE: sv/chained_hash_map_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_map_core: key-to-record table with separate chaining
// Buckets, entry fields, links and free list held in single-port RAMs.
// ----------------------------------------------------------------------------
// Channel | Direction | Signals
// in      | input     | in_valid_i, in_stall_o, in_data_i (chm_in_t)
// out     | output    | out_valid_o, out_stall_i, out_data_o (chm_out_t)
//
// Sequence: lookup or remove reads the bucket head, then walks the chain
//   (none on an empty bucket); a remove that unlinks adds S_LINK and S_FETCH;
//   insert ends with StFull on a full pool, else links a free entry as head
//   or at the chain's tail; an unused code goes straight to S_DONE.
// Reset: a clearing pass empties the bucket table and fills the free stack;
//   no item is taken meanwhile.
// Stalls: the result waits in an output register; the next item is taken
//   once the previous result has left.
// ----------------------------------------------------------------------------
module chained_hash_map_core
  import chm_pkg::*;
#(
  parameter int unsigned Buckets     = BucketsDefault,
  parameter int unsigned PoolEntries = PoolEntriesDefault,
  parameter int unsigned PayloadBits = PayloadBitsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  chm_pkg::chm_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output chm_pkg::chm_out_t out_data_o
);
  localparam int unsigned BW = $clog2(Buckets);
  localparam int unsigned EW = $clog2(PoolEntries);
  localparam int unsigned CW = EW + 1;
  localparam int unsigned ClrN = (Buckets > PoolEntries) ? Buckets : PoolEntries;
  localparam int unsigned KW = $clog2(ClrN) + 1;
  // entry record: key, number, payload, link valid, link
  localparam int unsigned RW = 32 + 32 + PayloadBits + 1 + EW;

  chm_state_e state_q, state_d;

  logic [1:0]   op_q;
  logic [31:0]  key_q, num_q;
  logic [PayloadBits-1:0] pay_q;
  logic [BW-1:0] bkt_q;
  logic [EW-1:0] cur_q, cur_d, prev_q, prev_d, new_q, new_d;
  logic          has_prev_q, has_prev_d;
  logic [CW-1:0] free_cnt_q, free_cnt_d;
  logic [KW-1:0] clr_q;
  logic          out_valid_q;
  chm_out_t      out_q, out_d;
  logic          out_load;

  // RAM ports
  logic          h_we;
  logic [BW-1:0] h_addr;
  logic [EW:0]   h_wd, h_rd;
  logic          e_we;
  logic [EW-1:0] e_addr;
  logic [RW-1:0] e_wd, e_rd;
  logic          f_we;
  logic [EW-1:0] f_addr, f_wd, f_rd;

  logic [31:0] e_key, e_num;
  logic [PayloadBits-1:0] e_pay;
  logic        e_lv;
  logic [EW-1:0] e_lnk;
  assign {e_key, e_num, e_pay, e_lv, e_lnk} = e_rd;

  logic in_acc;
  assign in_acc     = (state_q == S_IDLE) && in_valid_i && !out_valid_q;
  assign in_stall_o = !((state_q == S_IDLE) && !out_valid_q);

  chm_ram #(.Width(EW + 1), .Depth(Buckets)) u_heads (
    .clk_i, .we_i(h_we), .addr_i(h_addr), .wdata_i(h_wd), .rdata_o(h_rd));
  chm_ram #(.Width(RW), .Depth(PoolEntries)) u_entries (
    .clk_i, .we_i(e_we), .addr_i(e_addr), .wdata_i(e_wd), .rdata_o(e_rd));
  chm_ram #(.Width(EW), .Depth(PoolEntries)) u_free (
    .clk_i, .we_i(f_we), .addr_i(f_addr), .wdata_i(f_wd), .rdata_o(f_rd));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (clr_q == KW'(ClrN - 1)) state_d = S_IDLE;
      S_IDLE:  if (in_acc) begin
        if (in_data_i.operation == OpInsert || in_data_i.operation == OpRemove ||
            in_data_i.operation == OpLookup) state_d = S_HEAD;
        else state_d = S_DONE;
      end
      S_HEAD: begin
        if (op_q == OpInsert) state_d = (free_cnt_q == '0) ? S_DONE : S_FREE;
        else state_d = h_rd[EW] ? S_WALK : S_DONE;
      end
      // the entry RAM was busy with the new entry; reread the head entry
      S_FREE:  state_d = h_rd[EW] ? S_WALK_RD : S_DONE;
      S_WALK_RD: state_d = S_WALK;
      S_WALK: begin
        if (op_q == OpInsert) state_d = e_lv ? S_WALK_RD : S_DONE;
        else if (e_key == key_q) state_d = (op_q == OpRemove) ? S_LINK : S_DONE;
        else state_d = e_lv ? S_WALK_RD : S_DONE;
      end
      S_LINK:  state_d = S_FETCH;
      S_FETCH: state_d = S_DONE;
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and RAM controls
  always_comb begin
    h_we = 1'b0; h_addr = bkt_q; h_wd = '0;
    e_we = 1'b0; e_addr = cur_q; e_wd = '0;
    f_we = 1'b0; f_addr = EW'(free_cnt_q - 1'b1); f_wd = '0;
    cur_d = cur_q; prev_d = prev_q; has_prev_d = has_prev_q; new_d = new_q;
    free_cnt_d = free_cnt_q;
    out_load = 1'b0;
    out_d = '0;
    out_d.status = StMissing;
    unique case (state_q)
      S_CLEAR: begin
        h_addr = BW'(clr_q);
        h_we   = (clr_q < KW'(Buckets));
        f_addr = EW'(clr_q);
        f_wd   = EW'(PoolEntries - 1) - EW'(clr_q);
        f_we   = (clr_q < KW'(PoolEntries));
      end
      S_IDLE: begin
        h_addr = BW'(in_data_i.key % Buckets);
        has_prev_d = 1'b0;
        if (in_acc && !(in_data_i.operation == OpInsert ||
            in_data_i.operation == OpRemove || in_data_i.operation == OpLookup)) begin
          out_load = 1'b1;
        end
      end
      S_HEAD: begin
        // head read data valid; fetch the free index for inserts
        cur_d = h_rd[EW-1:0];
        e_addr = h_rd[EW-1:0];
        if (op_q == OpInsert) begin
          if (free_cnt_q == '0) begin
            out_load = 1'b1;
            out_d.status = StFull;
          end
        end else if (!h_rd[EW]) begin
          out_load = 1'b1;
        end
      end
      S_FREE: begin
        // write the new entry; hook to head if bucket empty
        new_d = f_rd;
        free_cnt_d = free_cnt_q - 1'b1;
        e_we = 1'b1;
        e_addr = f_rd;
        e_wd = {key_q, num_q, pay_q, 1'b0, EW'(0)};
        if (!h_rd[EW]) begin
          h_we = 1'b1;
          h_wd = {1'b1, f_rd};
          out_load = 1'b1;
          out_d.status = StOk;
        end
      end
      S_WALK_RD: e_addr = cur_q;
      S_WALK: begin
        e_addr = e_lnk;
        if (op_q == OpInsert) begin
          if (e_lv) cur_d = e_lnk;
          else begin
            e_we = 1'b1;
            e_addr = cur_q;
            e_wd = {e_key, e_num, e_pay, 1'b1, new_q};
            out_load = 1'b1;
            out_d.status = StOk;
          end
        end else if (e_key == key_q) begin
          if (op_q == OpLookup) begin
            out_load = 1'b1;
            out_d.status = StOk;
            out_d.found_number = e_num;
            out_d.found_payload = 64'(e_pay);
          end else begin
            // unlink: free entry, patch head or predecessor
            f_we = (free_cnt_q < CW'(PoolEntries));
            f_addr = EW'(free_cnt_q);
            f_wd = cur_q;
            if (free_cnt_q < CW'(PoolEntries)) free_cnt_d = free_cnt_q + 1'b1;
            new_d = e_lnk;
            prev_d = has_prev_q ? prev_q : cur_q;
            cur_d = {EW{1'b0}} | EW'(e_lv);
            if (!has_prev_q) begin
              h_we = 1'b1;
              h_wd = {e_lv, e_lnk};
            end
            e_addr = has_prev_q ? prev_q : cur_q;
            out_load = 1'b1;
            out_d.status = StOk;
          end
        end else begin
          if (e_lv) begin
            prev_d = cur_q; has_prev_d = 1'b1; cur_d = e_lnk;
          end else out_load = 1'b1;
        end
      end
      S_LINK: begin
        // entry at prev_q is being read; cur_q[0] holds the removed link valid
        e_addr = prev_q;
      end
      S_FETCH: begin
        if (has_prev_q) begin
          e_we = 1'b1;
          e_addr = prev_q;
          e_wd = {e_key, e_num, e_pay, cur_q[0], new_q};
        end
      end
      S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q <= '0;
      free_cnt_q <= CW'(PoolEntries);
      out_valid_q <= 1'b0;
      has_prev_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
      free_cnt_q <= free_cnt_d;
      has_prev_q <= has_prev_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q <= in_data_i.operation;
      key_q <= in_data_i.key;
      num_q <= in_data_i.record_number;
      pay_q <= in_data_i.record_payload[PayloadBits-1:0];
      bkt_q <= BW'(in_data_i.key % Buckets);
    end
    cur_q <= cur_d; prev_q <= prev_d; new_q <= new_d;
    if (out_load) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
endmodule

FILE: sv/chm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chm_ram: generic single-port synchronous RAM
// One access per cycle (a write also reads out the old word), read data registered.
// ----------------------------------------------------------------------------
module chm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

FILE: sv/chm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chm_checker: port-level checks for the chained hash map
// Watches handshakes and result codes on the top level's ports.
// ----------------------------------------------------------------------------
module chm_checker
  import chm_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input chm_pkg::chm_out_t out_data_o,
  input logic              out_valid_o,
  input logic              out_stall_i
);
  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed under stall");
  // status is a defined code
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status == StOk || out_data_o.status == StMissing ||
                     out_data_o.status == StFull))
    else $error("bad status");
  // no input taken while a result waits
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input accepted with result pending");
  // an accepted item blocks the next cycle
  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("back to back accept");
endmodule

bind chained_hash_map_core chm_checker u_chm_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_data_o, .out_valid_o, .out_stall_i);
